// ===== design/rgb_to_led_channel_map_core_defines.svh =====
// Assertion macros shared by the LED channel map checker.
`ifndef RGB_TO_LED_CHANNEL_MAP_CORE_DEFINES_SVH
`define RGB_TO_LED_CHANNEL_MAP_CORE_DEFINES_SVH

// Check on every clock edge outside reset.
`define RLCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RLCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/rlcm_pkg.sv =====
// Shared types, Q1.24 constants and helper functions of the LED channel map.
`default_nettype none

package rlcm_pkg;

  localparam int unsigned Q_W    = 25;
  localparam int unsigned Q_FRAC = 24;
  localparam int unsigned N_STAGES = 11;

  typedef logic [Q_W-1:0] q_t;

  localparam q_t Q_ONE     = 25'h100_0000;
  localparam q_t K_LUMA_R  = 25'd5016387;
  localparam q_t K_LUMA_G  = 25'd9848226;
  localparam q_t K_LUMA_B  = 25'd1912603;
  localparam q_t K_GAIN_06 = 25'd10066330;
  localparam q_t K_GAIN_09 = 25'd15099494;

  typedef struct packed {
    q_t white;
    q_t red;
    q_t green;
    q_t blue;
  } level_t;

  // white sits in the lowest byte of the output word
  typedef struct packed {
    logic [7:0] yellow;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] white;
  } drive_t;

  // round(c * 2^24 / 255) equals c * 65793 plus one for the upper half
  function automatic q_t norm8(input logic [7:0] c);
    return q_t'({c, c, c}) + q_t'(c[7]);
  endfunction

  // floor(v * 255), clipped at one
  function automatic logic [7:0] to_byte(input q_t v);
    logic [32:0] t;
    t = {v, 8'b0} - {8'b0, v};
    if (v > Q_ONE) begin
      return 8'hFF;
    end
    return t[31:24];
  endfunction

endpackage

`default_nettype wire

// ===== design/rlcm_qmul.sv =====
// Registered Q1.24 multiply, product truncated to 24 fraction bits.
`default_nettype none

module rlcm_qmul
  import rlcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire q_t   a_i,
  input  wire q_t   b_i,
  output q_t        p_o
);

  logic [2*Q_W-1:0] prod;
  q_t               p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod[Q_FRAC+Q_W-1:Q_FRAC];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== design/rlcm_dly.sv =====
// Enabled delay line that keeps operands aligned with the multiply stages.
`default_nettype none

module rlcm_dly #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tap_q[0] <= d_i;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tap_q[i] <= tap_q[i-1];
        end
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/rlcm_outbuf.sv =====
// Byte conversion, yellow difference and output register with skid word.
`default_nettype none

module rlcm_outbuf
  import rlcm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire level_t level_i,
  output logic        pipe_en_o,
  output logic        m_valid_o,
  input  wire logic   m_ready_i,
  output drive_t      m_data_o
);

  q_t     yellow;
  drive_t drive;
  logic   push, pop;

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  drive_t out_data_q, out_data_d;
  drive_t skid_data_q, skid_data_d;

  // clip the difference at zero
  assign yellow = (level_i.white < level_i.blue) ? '0 : level_i.white - level_i.blue;

  always_comb begin
    drive.white  = to_byte(level_i.white);
    drive.red    = to_byte(level_i.red);
    drive.green  = to_byte(level_i.green);
    drive.blue   = to_byte(level_i.blue);
    drive.yellow = to_byte(yellow);
  end

  // freeze the pipeline only while the skid word is occupied
  assign pipe_en_o = !skid_valid_q;
  assign push      = valid_i && pipe_en_o;
  assign pop       = out_valid_q && m_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_d = push;
      out_data_d  = drive;
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = drive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== design/rgb_to_led_channel_map_core.sv =====
// Top level of the RGB pixel to five-channel LED drive map.
//
//   channel  dir  tdata bits (low to high)                       tuser  tlast
//   s_axis   in   pixel_rgb[23:0] (blue 7:0, green 15:8, red 23:16)  -      -
//   m_axis   out  white_drive[7:0], red_drive[15:8],               -      -
//                 green_drive[23:16], blue_drive[31:24],
//                 yellow_drive[39:32]
//
// Takes one word per cycle while s_axis_tready is high. The pipeline depth is set
// by the red chain: normalize, eight multiplies for the 67th power and two gain
// multiplies, one 25x25 multiply per stage, plus the output register. Reset clears
// the stage valid bits and the valid flags of the output buffer only.
// Under an output stall the buffer parks one extra word in a skid register;
// the stages freeze (and s_axis_tready drops) only while that word is held.
`default_nettype none

module rgb_to_led_channel_map_core
  import rlcm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pixel_rgb[23:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata    // white, red, green, blue, yellow (8 bits each)
);

  logic                en;
  logic [N_STAGES-1:0] vld_q;

  // stage 1: normalized channels
  q_t rn_q, gn_q, bn_q;

  // luma path
  q_t          lr, lg, lb;
  logic [26:0] luma_sum;
  q_t          y_s3, y_s4, y2, y3, y6, wht, wht_s11;

  // red path
  q_t r_s6, r_s8, r2, r4, r8, r16, r32, r33, r66, r67, rk, red;

  // green path
  q_t g_s3, g2, g4, g5, grn, grn_s11;

  // blue path
  q_t b2, b4, blu, blu_s11;

  level_t level;
  drive_t drive;

  // advance every stage together; bubbles travel as cleared valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STAGES-2:0], s_axis_tvalid};
    end
  end

  assign s_axis_tready = en;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q <= norm8(s_axis_tdata[23:16]);
      gn_q <= norm8(s_axis_tdata[15:8]);
      bn_q <= norm8(s_axis_tdata[7:0]);
    end
  end

  // stage 2: luma terms and first squares
  rlcm_qmul u_lr (.clk_i, .en_i(en), .a_i(rn_q), .b_i(K_LUMA_R), .p_o(lr));
  rlcm_qmul u_lg (.clk_i, .en_i(en), .a_i(gn_q), .b_i(K_LUMA_G), .p_o(lg));
  rlcm_qmul u_lb (.clk_i, .en_i(en), .a_i(bn_q), .b_i(K_LUMA_B), .p_o(lb));
  rlcm_qmul u_r2 (.clk_i, .en_i(en), .a_i(rn_q), .b_i(rn_q),     .p_o(r2));
  rlcm_qmul u_g2 (.clk_i, .en_i(en), .a_i(gn_q), .b_i(gn_q),     .p_o(g2));
  rlcm_qmul u_b2 (.clk_i, .en_i(en), .a_i(bn_q), .b_i(bn_q),     .p_o(b2));

  // hold the base operands until their multiply stage
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(5)) u_r_s6 (.clk_i, .en_i(en), .d_i(rn_q), .q_o(r_s6));
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(2)) u_r_s8 (.clk_i, .en_i(en), .d_i(r_s6), .q_o(r_s8));
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(2)) u_g_s3 (.clk_i, .en_i(en), .d_i(gn_q), .q_o(g_s3));

  // stage 3: luma sum, fourth powers (weights sum to one, so luma fits Q1.24)
  assign luma_sum = {2'b0, lr} + {2'b0, lg} + {2'b0, lb};

  rlcm_dly #(.WIDTH(Q_W), .DEPTH(1)) u_y_s3 (.clk_i, .en_i(en), .d_i(luma_sum[Q_W-1:0]),
                                             .q_o(y_s3));
  rlcm_qmul u_r4 (.clk_i, .en_i(en), .a_i(r2), .b_i(r2), .p_o(r4));
  rlcm_qmul u_g4 (.clk_i, .en_i(en), .a_i(g2), .b_i(g2), .p_o(g4));
  rlcm_qmul u_b4 (.clk_i, .en_i(en), .a_i(b2), .b_i(b2), .p_o(b4));

  // stage 4
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(1)) u_y_s4 (.clk_i, .en_i(en), .d_i(y_s3), .q_o(y_s4));
  rlcm_qmul u_y2  (.clk_i, .en_i(en), .a_i(y_s3), .b_i(y_s3),      .p_o(y2));
  rlcm_qmul u_r8  (.clk_i, .en_i(en), .a_i(r4),   .b_i(r4),        .p_o(r8));
  rlcm_qmul u_g5  (.clk_i, .en_i(en), .a_i(g4),   .b_i(g_s3),      .p_o(g5));
  rlcm_qmul u_blu (.clk_i, .en_i(en), .a_i(b4),   .b_i(K_GAIN_09), .p_o(blu));

  // stage 5
  rlcm_qmul u_y3  (.clk_i, .en_i(en), .a_i(y2), .b_i(y_s4),      .p_o(y3));
  rlcm_qmul u_r16 (.clk_i, .en_i(en), .a_i(r8), .b_i(r8),        .p_o(r16));
  rlcm_qmul u_grn (.clk_i, .en_i(en), .a_i(g5), .b_i(K_GAIN_09), .p_o(grn));

  // stage 6
  rlcm_qmul u_y6  (.clk_i, .en_i(en), .a_i(y3),  .b_i(y3),  .p_o(y6));
  rlcm_qmul u_r32 (.clk_i, .en_i(en), .a_i(r16), .b_i(r16), .p_o(r32));

  // stage 7
  rlcm_qmul u_wht (.clk_i, .en_i(en), .a_i(y6),  .b_i(K_GAIN_06), .p_o(wht));
  rlcm_qmul u_r33 (.clk_i, .en_i(en), .a_i(r32), .b_i(r_s6),      .p_o(r33));

  // stages 8 to 11: finish the red chain
  rlcm_qmul u_r66 (.clk_i, .en_i(en), .a_i(r33), .b_i(r33),      .p_o(r66));
  rlcm_qmul u_r67 (.clk_i, .en_i(en), .a_i(r66), .b_i(r_s8),     .p_o(r67));
  rlcm_qmul u_rk  (.clk_i, .en_i(en), .a_i(r67), .b_i(K_GAIN_09), .p_o(rk));
  rlcm_qmul u_red (.clk_i, .en_i(en), .a_i(rk),  .b_i(K_GAIN_06), .p_o(red));

  // align the early finishers with red at stage 11
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(4)) u_wht_s11 (.clk_i, .en_i(en), .d_i(wht), .q_o(wht_s11));
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(6)) u_grn_s11 (.clk_i, .en_i(en), .d_i(grn), .q_o(grn_s11));
  rlcm_dly #(.WIDTH(Q_W), .DEPTH(7)) u_blu_s11 (.clk_i, .en_i(en), .d_i(blu), .q_o(blu_s11));

  always_comb begin
    level.white = wht_s11;
    level.red   = red;
    level.green = grn_s11;
    level.blue  = blu_s11;
  end

  rlcm_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .valid_i   (vld_q[N_STAGES-1]),
    .level_i   (level),
    .pipe_en_o (en),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (drive)
  );

  assign m_axis_tdata = drive;

endmodule

`default_nettype wire

// ===== design/rlcm_checker.sv =====
// Port-level checker for the LED channel map, bound to the top level.
`default_nettype none

`include "rgb_to_led_channel_map_core_defines.svh"

module rlcm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

  // a stalled output word holds
  `RLCM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")

  // with nothing waiting at the output, the input side is open
  `RLCM_ASSERT_ALWAYS(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

  // the input side closes only after an output stall
  `RLCM_ASSERT(a_ready_fall, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input blocked without output stall")

  // a taken output word frees the skid word at once
  `RLCM_ASSERT(a_ready_after_pop, m_axis_tvalid && m_axis_tready |=> s_axis_tready, "input blocked after output handshake")

  // yellow is white minus blue, so its byte never exceeds white
  `RLCM_ASSERT(a_yellow_le_white, m_axis_tvalid |-> m_axis_tdata[39:32] <= m_axis_tdata[7:0], "yellow above white")

endmodule

bind rgb_to_led_channel_map_core rlcm_checker u_rlcm_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of the RGB pixel to five-channel LED drive map.
module testbench;
  import rlcm_pkg::drive_t;

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned RESET_CYCLES = 11;
  // pipeline depth is 12; leave margin for the skid register
  localparam int unsigned SETTLE_CYCLES = 30;
  // ~800 words, each with drawn idle gaps and sink stalls, taken many times over
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Q1.24 arithmetic, held in 64 bits so no product overflows
  localparam int unsigned FRAC_BITS = 24;
  localparam logic [63:0] UNITY     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] W_RED     = 64'd5016387;   // 0.299
  localparam logic [63:0] W_GREEN   = 64'd9848226;   // 0.587
  localparam logic [63:0] W_BLUE    = 64'd1912603;   // 0.114
  localparam logic [63:0] GAIN_SIX  = 64'd10066330;  // 0.6
  localparam logic [63:0] GAIN_NINE = 64'd15099494;  // 0.9
  localparam logic [7:0]  POW_WHITE = 8'd6;
  localparam logic [7:0]  POW_RED   = 8'd67;
  localparam logic [7:0]  POW_GREEN = 8'd5;
  localparam logic [7:0]  POW_BLUE  = 8'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel_rgb[23:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // white, red, green, blue, yellow (8 bits each)

  drive_t pending_drives[$];
  int     mismatch_count;
  int     pixels_sent;
  int     words_checked;
  int     cycle_count;
  int     src_gap_max;
  int     sink_stall_max;

  rgb_to_led_channel_map_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------------------------------------------------------- prediction

  // product of two Q1.24 values, truncated to 24 fraction bits
  function automatic logic [63:0] q_product(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> FRAC_BITS;
  endfunction

  // channel byte to Q1.24, round to nearest (no ties since 255 is odd)
  function automatic logic [63:0] channel_level(input logic [7:0] c);
    return ((64'(c) << FRAC_BITS) + 64'd127) / 64'd255;
  endfunction

  // square-and-multiply, starting from the top exponent bit
  function automatic logic [63:0] q_power(input logic [63:0] base, input logic [7:0] expo);
    logic [63:0] acc;
    acc = UNITY;
    for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
      acc = q_product(acc, acc);
      if (expo[bit_idx]) begin
        acc = q_product(acc, base);
      end
    end
    return acc;
  endfunction

  // floor(v * 255), clipped at one
  function automatic logic [7:0] drive_byte(input logic [63:0] v);
    logic [63:0] clipped;
    clipped = (v > UNITY) ? UNITY : v;
    return 8'((clipped * 64'd255) >> FRAC_BITS);
  endfunction

  function automatic drive_t led_drive_of(input logic [23:0] pixel);
    logic [63:0] red_lvl, green_lvl, blue_lvl, luma;
    logic [63:0] white_out, red_out, green_out, blue_out, yellow_out;
    drive_t      drive;
    red_lvl   = channel_level(pixel[23:16]);
    green_lvl = channel_level(pixel[15:8]);
    blue_lvl  = channel_level(pixel[7:0]);
    luma = q_product(W_RED, red_lvl) + q_product(W_GREEN, green_lvl)
         + q_product(W_BLUE, blue_lvl);
    white_out = q_product(q_power(luma, POW_WHITE), GAIN_SIX);
    red_out   = q_product(q_product(q_power(red_lvl, POW_RED), GAIN_NINE), GAIN_SIX);
    green_out = q_product(q_power(green_lvl, POW_GREEN), GAIN_NINE);
    blue_out  = q_product(q_power(blue_lvl, POW_BLUE), GAIN_NINE);
    // yellow floors at zero when blue outshines white
    yellow_out = (white_out < blue_out) ? 64'd0 : white_out - blue_out;
    if (yellow_out > UNITY) begin
      yellow_out = UNITY;
    end
    drive.white  = drive_byte(white_out);
    drive.red    = drive_byte(red_out);
    drive.green  = drive_byte(green_out);
    drive.blue   = drive_byte(blue_out);
    drive.yellow = drive_byte(yellow_out);
    return drive;
  endfunction

  // ---------------------------------------------------------------- clock, limit

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending",
               cycle_count, pending_drives.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sink side

  // draw a stall per word; hold ready high until the word is taken
  initial begin : sink_driver
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each taken word with the oldest prediction
  always @(posedge clk_i) begin
    drive_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = drive_t'(m_axis_tdata);
      words_checked++;
      if (pending_drives.size() == 0) begin
        $error("result word %h arrived with no pixel pending", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        if (got.white !== want.white) begin
          $error("white_drive: expected %0d, got %0d", want.white, got.white);
          mismatch_count++;
        end
        if (got.red !== want.red) begin
          $error("red_drive: expected %0d, got %0d", want.red, got.red);
          mismatch_count++;
        end
        if (got.green !== want.green) begin
          $error("green_drive: expected %0d, got %0d", want.green, got.green);
          mismatch_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_drive: expected %0d, got %0d", want.blue, got.blue);
          mismatch_count++;
        end
        if (got.yellow !== want.yellow) begin
          $error("yellow_drive: expected %0d, got %0d", want.yellow, got.yellow);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- source side

  // idle for a drawn gap, then hold the pixel until it is taken
  task automatic send_pixel(input logic [23:0] pixel);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drives.push_back(led_drive_of(pixel));
    pixels_sent++;
  endtask

  // bias toward bright values: the high powers crush anything dim to zero
  function automatic logic [7:0] draw_channel();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0, 1: c = 8'($urandom_range(0, 255));
      2:    c = 8'($urandom_range(200, 255));
      3:    c = 8'($urandom_range(240, 255));
      default: begin
        case ($urandom_range(0, 3))
          0:       c = 8'h00;
          1:       c = 8'h01;
          2:       c = 8'hFE;
          default: c = 8'hFF;
        endcase
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  // corners: all off, all on, each channel alone, blue above white, mid-scale
  task automatic test_corner_pixels();
    logic [23:0] corners[$];
    corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010101, 24'hFEFEFE,
                24'hFE0000, 24'h00FE00, 24'h0000FE, 24'hFFFFFE, 24'h808080,
                24'h7F7F7F, 24'h800000, 24'h008000, 24'h000080, 24'hF0F0F0,
                24'h0F0F0F, 24'hAA55AA, 24'h55AA55, 24'hFEFF01};
    src_gap_max    = 0;
    sink_stall_max = 0;
    foreach (corners[i]) begin
      send_pixel(corners[i]);
    end
  endtask

  // random pixels; switch idling on and off every 50 words on both sides
  task automatic test_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 10;
        sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      end
      send_pixel({draw_channel(), draw_channel(), draw_channel()});
    end
  endtask

  // source flat out against a stalling sink: fill the skid register
  task automatic test_back_pressure(input int count);
    src_gap_max    = 0;
    sink_stall_max = 10;
    for (int i = 0; i < count; i++) begin
      send_pixel(24'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatch_count = 0;
    pixels_sent    = 0;
    words_checked  = 0;
    cycle_count    = 0;
    src_gap_max    = 0;
    sink_stall_max = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_random_pixels(500);
    test_back_pressure(250);
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle so stray words show up
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels (corners, biased random, back-pressure burst),",
             pixels_sent);
    $display("checked %0d drive words with random gaps and stalls on both sides.",
             words_checked);
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rlcm_pkg.sv
design/rlcm_qmul.sv
design/rlcm_dly.sv
design/rlcm_outbuf.sv
design/rgb_to_led_channel_map_core.sv
design/rlcm_checker.sv
dv/testbench.sv
